FILE: design/ufv_pkg.sv
// ufv_pkg: shared types, codes and helper functions for the UTF-8 filename validator.
// Used by every module of the validator; depends on nothing else.
package ufv_pkg;

    // Widths fixed by the interface
    localparam int CFG_W          = 12;
    localparam int NAME_LEN_W     = 13;
    localparam int CP_W           = 21;

    // Defaults for top-level parameters and registers
    localparam int              LENGTH_COUNT_BITS_DEFAULT = 13;
    localparam logic [CFG_W-1:0] MAX_LENGTH_RESET          = 12'd255;

    // Verdict / error codes; first_error uses OK, BAD_UTF8 and CONTROL only
    typedef enum logic [2:0] {
        REASON_OK        = 3'd0,
        REASON_EMPTY     = 3'd1,
        REASON_TOO_LONG  = 3'd2,
        REASON_BAD_UTF8  = 3'd3,
        REASON_CONTROL   = 3'd4,
        REASON_SEPARATOR = 3'd5,
        REASON_DOT_NAME  = 3'd6
    } reason_t;

    // Shape of the name so far: empty, ".", "..", or anything else
    typedef enum logic [1:0] {
        DOT_NONE  = 2'd0,
        DOT_ONE   = 2'd1,
        DOT_TWO   = 2'd2,
        DOT_OTHER = 2'd3
    } dot_shape_t;

    typedef logic [CFG_W-1:0]      cfg_t;
    typedef logic [NAME_LEN_W-1:0] name_len_t;
    typedef logic [CP_W-1:0]       codepoint_t;

    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;

    // One input item as held in the input register
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } item_t;

    // One verdict, from the tracker to the result register
    typedef struct packed {
        logic      accepted;
        reason_t   reason;
        name_len_t length;
    } verdict_t;

    // Smallest codepoint allowed for a sequence class (1 to 4 bytes)
    function automatic codepoint_t min_for_class(input logic [1:0] cls);
        codepoint_t m;
        case (cls)
            2'd0:    m = 21'h000000;
            2'd1:    m = 21'h000080;
            2'd2:    m = 21'h000800;
            2'd3:    m = 21'h010000;
            default: m = 21'h000000;
        endcase
        return m;
    endfunction

    // Classify a completed codepoint
    function automatic reason_t judge_codepoint(input codepoint_t cp, input logic [1:0] cls);
        reason_t r;
        if ((cp < min_for_class(cls)) || (cp > 21'h10FFFF) ||
            (cp inside {[21'h00D800:21'h00DFFF]}))
            r = REASON_BAD_UTF8;
        else if ((cp < 21'h000020) || (cp == 21'h00007F) ||
                 (cp inside {[21'h000080:21'h00009F]}))
            r = REASON_CONTROL;
        else
            r = REASON_OK;
        return r;
    endfunction

endpackage

FILE: design/utf8_filename_validator_core.sv
// utf8_filename_validator_core: top level of the streaming UTF-8 filename validator.
// Depends on ufv_pkg, ufv_input_stage and ufv_name_tracker.
//
// Usage:
//   Input channel (in_valid / in_stall): one item per byte of the filename,
//   data_byte with has_byte = 1; last = 1 ends the name. An item with
//   has_byte = 0 and last = 1 ends a name without adding a byte (empty names).
//   Output channel (out_valid / out_stall): one verdict per name, given for
//   the item with last = 1: accepted, reject_reason, name_length.
//   Config channel (cfg_valid / cfg_ready / cfg_data): writes max_length;
//   cfg_ready is always high. Write only while no name is in flight.
// Timing:
//   One item per cycle sustained unless a stalled verdict holds an item with
//   last. An item waits in the input register; its state update and verdict
//   are formed from it, and the verdict is registered as the last item moves on.
//   If out_stall holds a verdict, items without last keep flowing; an item
//   with last waits in the input register, and only then is in_stall raised.
// Reset: clears the name state and both valid flags; max_length returns to 255.
module utf8_filename_validator_core #(
    parameter int LENGTH_COUNT_BITS = ufv_pkg::LENGTH_COUNT_BITS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // input items
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                data_byte,
    input  logic                      has_byte,
    input  logic                      last,
    // verdicts
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      accepted,
    output logic [2:0]                reject_reason,
    output ufv_pkg::name_len_t        name_length,
    // configuration
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  ufv_pkg::cfg_t             cfg_data
);
    import ufv_pkg::*;

    item_t    in_item;
    item_t    item;
    logic     item_valid;
    logic     proceed;
    logic     take;
    verdict_t verdict;

    cfg_t     max_length_reg;
    logic     out_valid_reg, out_valid_next;
    verdict_t result_reg;

    assign in_item.data_byte = data_byte;
    assign in_item.has_byte  = has_byte;
    assign in_item.last      = last;

    // A held item moves on unless it needs the result slot and the slot is blocked
    assign proceed = !item.last || !out_valid_reg || !out_stall;
    assign take    = item_valid && proceed;

    ufv_input_stage u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .proceed    (proceed),
        .item_valid (item_valid),
        .item       (item)
    );

    ufv_name_tracker #(
        .LENGTH_COUNT_BITS (LENGTH_COUNT_BITS)
    ) u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .item       (item),
        .max_length (max_length_reg),
        .verdict    (verdict)
    );

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_length_reg <= MAX_LENGTH_RESET;
        else if (cfg_valid && cfg_ready)
            max_length_reg <= cfg_data;
    end

    // Result register
    always_comb
    begin
        if (take && item.last)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take && item.last)
            result_reg <= verdict;
    end

    assign out_valid     = out_valid_reg;
    assign accepted      = result_reg.accepted;
    assign reject_reason = result_reg.reason;
    assign name_length   = result_reg.length;

endmodule

FILE: design/ufv_input_stage.sv
// ufv_input_stage: input register of the validator, with valid/stall handshake.
// Depends on ufv_pkg (item_t).
module ufv_input_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  ufv_pkg::item_t in_item,
    input  logic          proceed,
    output logic          item_valid,
    output ufv_pkg::item_t item
);
    import ufv_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    // Hold off the sender only while the held item cannot move on
    assign in_stall = valid_reg && !proceed;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (proceed)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= in_item;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: design/ufv_name_tracker.sv
// ufv_name_tracker: per-name state (count, UTF-8 decoder, first error, shape) and verdict logic.
// Depends on ufv_pkg (item_t, verdict_t, codes, judge_codepoint).
module ufv_name_tracker #(
    parameter int LENGTH_COUNT_BITS = ufv_pkg::LENGTH_COUNT_BITS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  ufv_pkg::item_t   item,
    input  ufv_pkg::cfg_t    max_length,
    output ufv_pkg::verdict_t verdict
);
    import ufv_pkg::*;

    localparam int CMP_W = (LENGTH_COUNT_BITS > CFG_W) ? LENGTH_COUNT_BITS : CFG_W;
    typedef logic [LENGTH_COUNT_BITS-1:0] count_t;
    typedef logic [CMP_W-1:0]             cmp_t;

    count_t     count_reg,  count_next,  count_b;
    logic [1:0] pend_reg,   pend_next,   pend_b;
    codepoint_t acc_reg,    acc_next,    acc_b;
    logic [1:0] cls_reg,    cls_next,    cls_b;
    reason_t    err_reg,    err_next,    err_b;
    logic       sep_reg,    sep_next,    sep_b;
    dot_shape_t dot_reg,    dot_next,    dot_b;

    logic       [7:0] b;
    logic       [1:0] pend_dec;
    codepoint_t acc_cont;
    reason_t    err_final;
    reason_t    reason;
    logic       too_long;

    assign b        = item.data_byte;
    assign pend_dec = pend_reg - 2'd1;
    assign acc_cont = {acc_reg[CP_W-7:0], b[5:0]};

    // State after taking this item's byte
    always_comb
    begin
        count_b = count_reg;
        pend_b  = pend_reg;
        acc_b   = acc_reg;
        cls_b   = cls_reg;
        err_b   = err_reg;
        sep_b   = sep_reg;
        dot_b   = dot_reg;
        if (item.has_byte)
        begin
            // saturating length count
            if ((cmp_t'(count_reg) <= cmp_t'(max_length)) && (count_reg != '1))
                count_b = count_reg + count_t'(1);
            if (b == CHAR_SLASH)
                sep_b = 1'b1;
            if ((b == CHAR_DOT) && (dot_reg == DOT_NONE))
                dot_b = DOT_ONE;
            else if ((b == CHAR_DOT) && (dot_reg == DOT_ONE))
                dot_b = DOT_TWO;
            else
                dot_b = DOT_OTHER;
            // decoder stops at the first error
            if (err_reg == REASON_OK)
            begin
                if (pend_reg == 2'd0)
                begin
                    if (b[7] == 1'b0)
                    begin
                        cls_b = 2'd0;
                        err_b = judge_codepoint(codepoint_t'(b), 2'd0);
                    end
                    else if (b[7:5] == 3'b110)
                    begin
                        cls_b  = 2'd1;
                        pend_b = 2'd1;
                        acc_b  = codepoint_t'(b[4:0]);
                    end
                    else if (b[7:4] == 4'b1110)
                    begin
                        cls_b  = 2'd2;
                        pend_b = 2'd2;
                        acc_b  = codepoint_t'(b[3:0]);
                    end
                    else if (b[7:3] == 5'b11110)
                    begin
                        cls_b  = 2'd3;
                        pend_b = 2'd3;
                        acc_b  = codepoint_t'(b[2:0]);
                    end
                    else
                        err_b = REASON_BAD_UTF8;
                end
                else if (b[7:6] != 2'b10)
                    err_b = REASON_BAD_UTF8;
                else
                begin
                    acc_b  = acc_cont;
                    pend_b = pend_dec;
                    if (pend_dec == 2'd0)
                        err_b = judge_codepoint(acc_cont, cls_reg);
                end
            end
        end
    end

    // Verdict from the state after this item
    always_comb
    begin
        err_final = err_b;
        if ((err_b == REASON_OK) && (pend_b != 2'd0))
            err_final = REASON_BAD_UTF8;
        too_long = cmp_t'(count_b) > cmp_t'(max_length);
        if (count_b == '0)
            reason = REASON_EMPTY;
        else if (too_long)
            reason = REASON_TOO_LONG;
        else if (err_final != REASON_OK)
            reason = err_final;
        else if (sep_b)
            reason = REASON_SEPARATOR;
        else if ((dot_b == DOT_ONE) || (dot_b == DOT_TWO))
            reason = REASON_DOT_NAME;
        else
            reason = REASON_OK;
        verdict.accepted = (reason == REASON_OK);
        verdict.reason   = reason;
        verdict.length   = name_len_t'(count_b);
    end

    // Clear after the last item, else keep the updated state
    always_comb
    begin
        count_next = count_reg;
        pend_next  = pend_reg;
        acc_next   = acc_reg;
        cls_next   = cls_reg;
        err_next   = err_reg;
        sep_next   = sep_reg;
        dot_next   = dot_reg;
        if (take)
        begin
            if (item.last)
            begin
                count_next = '0;
                pend_next  = 2'd0;
                acc_next   = '0;
                cls_next   = 2'd0;
                err_next   = REASON_OK;
                sep_next   = 1'b0;
                dot_next   = DOT_NONE;
            end
            else
            begin
                count_next = count_b;
                pend_next  = pend_b;
                acc_next   = acc_b;
                cls_next   = cls_b;
                err_next   = err_b;
                sep_next   = sep_b;
                dot_next   = dot_b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pend_reg  <= 2'd0;
            acc_reg   <= '0;
            cls_reg   <= 2'd0;
            err_reg   <= REASON_OK;
            sep_reg   <= 1'b0;
            dot_reg   <= DOT_NONE;
        end
        else
        begin
            count_reg <= count_next;
            pend_reg  <= pend_next;
            acc_reg   <= acc_next;
            cls_reg   <= cls_next;
            err_reg   <= err_next;
            sep_reg   <= sep_next;
            dot_reg   <= dot_next;
        end
    end

endmodule

FILE: design/ufv_checker.sv
// ufv_checker: port-level checks on the validator's verdict channel, bound to the top level.
// Depends on ufv_pkg (reason codes) and utf8_filename_validator_core.
module ufv_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic               accepted,
    input  logic [2:0]         reject_reason,
    input  ufv_pkg::name_len_t name_length
);
    import ufv_pkg::*;

    // A stalled verdict stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(accepted) &&
        $stable(reject_reason) && $stable(name_length))
        else $error("verdict changed while stalled");

    // accepted agrees with the reason code
    a_accept_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (accepted == (reject_reason == REASON_OK)))
        else $error("accepted disagrees with reject_reason");

    // Empty names, and only those, report zero length
    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (reject_reason == REASON_EMPTY) |-> (name_length == '0))
        else $error("empty verdict with nonzero length");

    a_len_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (name_length == '0) |-> (reject_reason == REASON_EMPTY))
        else $error("zero length without empty verdict");

endmodule

bind utf8_filename_validator_core ufv_checker u_ufv_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .accepted      (accepted),
    .reject_reason (reject_reason),
    .name_length   (name_length)
);

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for utf8_filename_validator_core, with its own verdict predictor.
// Depends on ufv_pkg and the validator RTL; needs no files or arguments at run time.

module testbench;
    import ufv_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 270;

    // DUT connections, all inputs known from time zero
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] data_byte = 8'h00;
    logic       has_byte  = 1'b0;
    logic       last      = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       accepted;
    logic [2:0] reject_reason;
    name_len_t  name_length;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    cfg_t       cfg_data  = '0;

    // Predictor state for the name in flight
    cfg_t       limit_model = MAX_LENGTH_RESET;
    name_len_t  count_model = '0;
    logic [1:0] pend_model  = 2'd0;
    codepoint_t cp_model    = '0;
    logic [1:0] class_model = 2'd0;
    reason_t    err_model   = REASON_OK;
    logic       sep_model   = 1'b0;
    dot_shape_t shape_model = DOT_NONE;

    verdict_t   verdicts_due[$];
    logic [7:0] name_buf[$];

    int errors        = 0;
    int items_sent    = 0;
    int verdicts_seen = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_seq      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int reason_hits[7];

    utf8_filename_validator_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .has_byte      (has_byte),
        .last          (last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .accepted      (accepted),
        .reject_reason (reject_reason),
        .name_length   (name_length),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Verdict class of a finished codepoint
    function automatic reason_t judge_cp(input codepoint_t cp, input logic [1:0] cls);
        codepoint_t floor_cp;
        floor_cp = (cls == 2'd0) ? 21'h000000 :
                   (cls == 2'd1) ? 21'h000080 :
                   (cls == 2'd2) ? 21'h000800 : 21'h010000;
        if (cp < floor_cp || cp > 21'h10FFFF || (cp >= 21'h00D800 && cp <= 21'h00DFFF))
            return REASON_BAD_UTF8;
        if (cp < 21'h000020 || cp == 21'h00007F || (cp >= 21'h000080 && cp <= 21'h00009F))
            return REASON_CONTROL;
        return REASON_OK;
    endfunction

    // Advance the predictor by one item; a last item queues its verdict
    task update_name_model(input logic [7:0] b, input logic hb, input logic lst);
        reason_t  decode_why;
        reason_t  why;
        verdict_t v;
        if (hb)
        begin
            // count saturates once past the limit, and at all ones
            if (count_model <= {1'b0, limit_model} && count_model != '1)
                count_model = count_model + name_len_t'(1);
            if (b == CHAR_SLASH)
                sep_model = 1'b1;
            if (b == CHAR_DOT && (shape_model == DOT_NONE || shape_model == DOT_ONE))
                shape_model = dot_shape_t'(shape_model + 2'd1);
            else
                shape_model = DOT_OTHER;
            // decoding stops at the first error
            if (err_model == REASON_OK)
            begin
                if (pend_model == 2'd0)
                begin
                    if (b[7] == 1'b0)
                    begin
                        class_model = 2'd0;
                        err_model   = judge_cp({13'd0, b}, 2'd0);
                    end
                    else if (b[7:5] == 3'b110)
                    begin
                        class_model = 2'd1;
                        pend_model  = 2'd1;
                        cp_model    = {16'd0, b[4:0]};
                    end
                    else if (b[7:4] == 4'b1110)
                    begin
                        class_model = 2'd2;
                        pend_model  = 2'd2;
                        cp_model    = {17'd0, b[3:0]};
                    end
                    else if (b[7:3] == 5'b11110)
                    begin
                        class_model = 2'd3;
                        pend_model  = 2'd3;
                        cp_model    = {18'd0, b[2:0]};
                    end
                    else
                        err_model = REASON_BAD_UTF8;
                end
                else if (b[7:6] != 2'b10)
                    err_model = REASON_BAD_UTF8;
                else
                begin
                    cp_model   = {cp_model[14:0], b[5:0]};
                    pend_model = pend_model - 2'd1;
                    if (pend_model == 2'd0)
                        err_model = judge_cp(cp_model, class_model);
                end
            end
        end
        if (lst)
        begin
            // a sequence cut off by the end of the name is bad UTF-8
            decode_why = (err_model == REASON_OK && pend_model != 2'd0) ? REASON_BAD_UTF8
                                                                        : err_model;
            if (count_model == '0)
                why = REASON_EMPTY;
            else if (count_model > {1'b0, limit_model})
                why = REASON_TOO_LONG;
            else if (decode_why != REASON_OK)
                why = decode_why;
            else if (sep_model)
                why = REASON_SEPARATOR;
            else if (shape_model == DOT_ONE || shape_model == DOT_TWO)
                why = REASON_DOT_NAME;
            else
                why = REASON_OK;
            v.accepted = (why == REASON_OK);
            v.reason   = why;
            v.length   = count_model;
            verdicts_due = {verdicts_due, v};
            count_model = '0;
            pend_model  = 2'd0;
            cp_model    = '0;
            class_model = 2'd0;
            err_model   = REASON_OK;
            sep_model   = 1'b0;
            shape_model = DOT_NONE;
        end
    endtask

    // Offer one item, with random idle cycles before it; returns once accepted
    task send_item(input logic [7:0] b, input logic hb, input logic lst);
        while (int'($urandom_range(99)) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        update_name_model(b, hb, lst);
        if (hb || lst)
            items_sent++;
        in_valid  <= 1'b1;
        data_byte <= b;
        has_byte  <= hb;
        last      <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Append one byte to the name being built
    task add_name_byte(input logic [7:0] byte_val);
        name_buf = {name_buf, byte_val};
    endtask

    // Send name_buf as one name, optionally closed by a bare end item
    task send_name(input bit bare_end, input int gap_pct);
        for (int i = 0; i < name_buf.size(); i++)
        begin
            if (int'($urandom_range(99)) < gap_pct)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(name_buf[i], 1'b1, !bare_end && (i == name_buf.size() - 1));
        end
        if (bare_end || name_buf.size() == 0)
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    // Stop offering, let every verdict arrive, then allow the pipeline to settle
    task wait_drained;
        in_valid <= 1'b0;
        @(posedge clk);
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write; only called with the block idle
    task write_max_length(input cfg_t v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid   <= 1'b0;
        limit_model = v;
    endtask

    // Append a codepoint in an nb-byte UTF-8 form (overlong if nb is too large)
    task append_cp(input logic [20:0] c, input int nb);
        case (nb)
            1: add_name_byte(c[7:0]);
            2:
            begin
                add_name_byte({3'b110, c[10:6]});
                add_name_byte({2'b10, c[5:0]});
            end
            3:
            begin
                add_name_byte({4'b1110, c[15:12]});
                add_name_byte({2'b10, c[11:6]});
                add_name_byte({2'b10, c[5:0]});
            end
            default:
            begin
                add_name_byte({5'b11110, c[20:18]});
                add_name_byte({2'b10, c[17:12]});
                add_name_byte({2'b10, c[11:6]});
                add_name_byte({2'b10, c[5:0]});
            end
        endcase
    endtask

    // Random name: mostly clean UTF-8, some with controls, noise and broken sequences
    task build_random_name;
        int         kind;
        int         nchars;
        int         r;
        int         nb;
        bit         clean;
        logic [20:0] c;
        name_buf.delete();
        kind = $urandom_range(99);
        if (kind < 5)
            return;
        if (kind < 10)
        begin
            nchars = $urandom_range(1, 3);
            repeat (nchars) add_name_byte(CHAR_DOT);
            return;
        end
        clean  = ($urandom_range(99) < 55);
        nchars = ($urandom_range(99) < 90) ? $urandom_range(1, 12) : $urandom_range(13, 40);
        repeat (nchars)
        begin
            r = clean ? $urandom_range(81) : $urandom_range(99);
            if (r < 4 && !clean)
                add_name_byte(CHAR_SLASH);
            else if (r < 10)
                add_name_byte(CHAR_DOT);
            else if (r < 45)
                add_name_byte(8'($urandom_range(8'h20, 8'h7E)));
            else if (r < 60)
                append_cp(21'($urandom_range(21'h80, 21'h7FF)), 2);
            else if (r < 72)
                append_cp(21'($urandom_range(21'h800, 21'hFFFF)), 3);
            else if (r < 82)
                append_cp(21'($urandom_range(21'h10000, 21'h10FFFF)), 4);
            else if (r < 88)
                add_name_byte(8'($urandom));
            else if (r < 92)
            begin
                c = 21'($urandom_range(32));
                add_name_byte((c == 21'd32) ? 8'h7F : c[7:0]);
            end
            else if (r < 95)
            begin
                // overlong form
                nb = $urandom_range(2, 4);
                c  = (nb == 2) ? 21'($urandom_range(21'h7F)) :
                     (nb == 3) ? 21'($urandom_range(21'h7FF)) : 21'($urandom_range(21'hFFFF));
                append_cp(c, nb);
            end
            else if (r < 97)
                append_cp(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
            else
            begin
                // lead byte with too few continuations
                nb = $urandom_range(2, 4);
                c  = 21'($urandom_range(21'h10000, 21'h10FFFF));
                append_cp(c, nb);
                void'(name_buf.pop_back());
            end
        end
    endtask

    // Receiver: random stall, or a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= (int'($urandom_range(99)) < stall_pct);
    end

    // Compare each accepted verdict with the oldest prediction
    always @(posedge clk)
    begin : check_verdicts
        verdict_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (verdicts_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected verdict, expected none, actual acc=%0b reason=%0d len=%0d",
                         $time, accepted, reject_reason, name_length);
            end
            else
            begin
                want = verdicts_due.pop_front();
                verdicts_seen++;
                reason_hits[int'(want.reason)]++;
                if (accepted !== want.accepted)
                begin
                    errors++;
                    $display("%0t: accepted mismatch, expected %0b, actual %0b",
                             $time, want.accepted, accepted);
                end
                if (reject_reason !== want.reason)
                begin
                    errors++;
                    $display("%0t: reject_reason mismatch, expected %0d, actual %0d",
                             $time, want.reason, reject_reason);
                end
                if (name_length !== want.length)
                begin
                    errors++;
                    $display("%0t: name_length mismatch, expected %0d, actual %0d",
                             $time, want.length, name_length);
                end
            end
        end
    end

    // Each rejection reason but too long, and each UTF-8 fault once, plus empty items mid-name
    task test_special_names;
        name_buf.delete();                          send_name(1'b0, 0);
        name_buf = '{8'h2E};                        send_name(1'b0, 0);
        name_buf = '{8'h2E, 8'h2E};                 send_name(1'b0, 0);
        name_buf = '{8'h2F};                        send_name(1'b0, 0);
        name_buf = '{8'h00};                        send_name(1'b0, 0);
        // C1 control in two-byte form
        name_buf = '{8'hC2, 8'h9F};                 send_name(1'b0, 0);
        // highest valid codepoint
        name_buf = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};   send_name(1'b0, 0);
        // overlong, surrogate, above range
        name_buf = '{8'hC0, 8'hAF};                 send_name(1'b0, 0);
        name_buf = '{8'hED, 8'hA0, 8'h80};          send_name(1'b0, 0);
        name_buf = '{8'hF4, 8'h90, 8'h80, 8'h80};   send_name(1'b0, 0);
        // stray continuation wins over the separator after it
        name_buf = '{8'h80, 8'h2F};                 send_name(1'b0, 0);
        // missing continuation, then sequence cut off at the end
        name_buf = '{8'hC3, 8'h41};                 send_name(1'b0, 0);
        name_buf = '{8'hE2, 8'h82};                 send_name(1'b0, 0);
        // bare item mid-name changes nothing
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        wait_drained();
    endtask

    // Small limits, zero limit, and a long name past the limit with count saturation
    task test_length_limits;
        write_max_length(12'd1);
        name_buf = '{8'h61, 8'h62};                 send_name(1'b0, 0);
        name_buf = '{8'h61};                        send_name(1'b1, 0);
        wait_drained();
        write_max_length(12'd0);
        name_buf = '{8'h61};                        send_name(1'b0, 0);
        name_buf.delete();                          send_name(1'b1, 0);
        wait_drained();
        write_max_length(12'd250);
        name_buf.delete();
        repeat (250) add_name_byte(8'h78);
        send_name(1'b0, 0);
        repeat (5) add_name_byte(8'h79);
        send_name(1'b1, 0);
        wait_drained();
        write_max_length(MAX_LENGTH_RESET);
    endtask

    // Random names under one idling profile and one limit
    task test_random_traffic(input int idle_pct, input int stall, input cfg_t lim);
        int target;
        wait_drained();
        write_max_length(lim);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        target        = items_sent + PHASE_ITEMS;
        while (items_sent < target)
        begin
            build_random_name();
            send_name($urandom_range(99) < 20, ($urandom_range(99) < 30) ? 10 : 0);
        end
        wait_drained();
    endtask

    // Long receiver hold-off while short names keep coming, so the input backs up
    task test_output_backpressure;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_seq++;
        repeat (80)
        begin
            name_buf.delete();
            repeat ($urandom_range(1, 2)) add_name_byte(8'($urandom_range(8'h30, 8'h7A)));
            send_name(1'b0, 0);
        end
        wait_drained();
    endtask

    // Test sequence
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_special_names();
        test_length_limits();
        test_random_traffic(0, 0, MAX_LENGTH_RESET);
        test_random_traffic(66, 0, cfg_t'($urandom_range(4, 24)));
        test_random_traffic(0, 66, 12'd4095);
        test_random_traffic(13, 13, cfg_t'($urandom_range(1, 12)));
        test_output_backpressure();
        $display("Covered %0d items and %0d verdicts over four idling profiles and a hold-off.",
                 items_sent, verdicts_seen);
        $display("Verdicts by reason ok/empty/long/utf8/ctrl/sep/dot: %0d %0d %0d %0d %0d %0d %0d",
                 reason_hits[0], reason_hits[1], reason_hits[2], reason_hits[3],
                 reason_hits[4], reason_hits[5], reason_hits[6]);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
